// File: src/atcp_pkg.sv
// Package for the ANSI text console parser: types, codes, constants, palette.
// No dependencies.
package atcp_pkg;

   localparam int MaxParamsDefault  = 8;
   localparam int MaxColumnsDefault = 512;
   localparam int RowLimit          = 256;
   localparam int ValueCap          = 9999;

   localparam logic [9:0] ColumnsReset = 10'd80;
   localparam logic [8:0] RowsReset    = 9'd25;

   localparam logic [7:0]  CharEsc   = 8'h1B;
   localparam logic [23:0] ForeReset = 24'hC0C0C0;
   localparam logic [23:0] ForeSgr0  = 24'hEEEEEE;

   typedef enum logic [1:0] {
      OP_WRITE  = 2'd0,
      OP_ERASE  = 2'd1,
      OP_SCROLL = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      PM_NORMAL = 2'd0,
      PM_ESC    = 2'd1,
      PM_CSI    = 2'd2,
      PM_DEC    = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SGR,
      ST_OUT1,
      ST_OUT2
   } state_type;

   localparam logic CSR_COLUMNS = 1'b0;
   localparam logic CSR_ROWS    = 1'b1;

   function automatic logic [23:0] palette(input logic [2:0] idx);
      case (idx)
         3'd0: palette = 24'h000000;
         3'd1: palette = 24'hAA0000;
         3'd2: palette = 24'h00AA00;
         3'd3: palette = 24'hAA5500;
         3'd4: palette = 24'h0000AA;
         3'd5: palette = 24'hAA00AA;
         3'd6: palette = 24'h00AAAA;
         default: palette = 24'hAAAAAA;
      endcase
   endfunction

endpackage

// File: src/atcp_sgr_unit.sv
// SGR colour unit: applies one select-graphic-rendition value per cycle.
// Depends on atcp_pkg.
module atcp_sgr_unit (
   input  logic [13:0] value,
   input  logic [23:0] fore_cur,
   input  logic [23:0] back_cur,
   output logic [23:0] fore_next,
   output logic [23:0] back_next
);
   logic [13:0] off;
   always_comb begin
      fore_next = fore_cur;
      back_next = back_cur;
      off = 14'd0;
      if (value == 14'd0) begin
         fore_next = atcp_pkg::ForeSgr0;
         back_next = 24'd0;
      end else if (value >= 14'd30 && value <= 14'd37) begin
         off = value - 14'd30;
         fore_next = atcp_pkg::palette(off[2:0]);
      end else if (value >= 14'd40 && value <= 14'd47) begin
         off = value - 14'd40;
         back_next = atcp_pkg::palette(off[2:0]);
      end
   end
endmodule

// File: src/ansi_text_console_parser_core.sv
// ANSI text console parser core: byte in, cell operations out.
// A byte with no result leaves the core in idle; each result adds one output state
// (ST_OUT1 for one result, then ST_OUT2 for a write plus wrap scroll) plus receiver stalls.
// An SGR final adds ST_SGR, one parameter per cycle in the SGR unit (up to MAX_PARAMS).
// One transaction in flight; req_ready and csr_ready stay low until its results are taken.
// Reset (synchronous, active high) returns mode, cursor, colours, geometry.
module ansi_text_console_parser_core #(
   parameter int MAX_PARAMS  = atcp_pkg::MaxParamsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_op,
   output logic [8:0]  rsp_cell_col,
   output logic [7:0]  rsp_cell_row,
   output logic [9:0]  rsp_span_end,
   output logic [7:0]  rsp_glyph_code,
   output logic [23:0] rsp_fore_rgb,
   output logic [23:0] rsp_back_rgb,
   output logic        rsp_last_op,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [9:0]  csr_data
);
   // Column and row fields are fixed at 9 and 8 bits, so the column limit is fixed too.
   localparam int MAX_COLUMNS = atcp_pkg::MaxColumnsDefault;
   localparam int PW = $clog2(MAX_PARAMS + 1);
   localparam int IW = $clog2(MAX_PARAMS);
   localparam logic [PW-1:0] PMAX = PW'(MAX_PARAMS);

   // Geometry registers and effective (clamped) values.
   logic [9:0] columns_ff;
   logic [8:0] rows_ff;
   logic [10:0] cols_eff;
   logic [8:0] rows_eff;
   always_comb begin
      cols_eff = {1'b0, columns_ff};
      if (columns_ff == 10'd0) cols_eff = 11'd1;
      if ({1'b0, columns_ff} > 11'(MAX_COLUMNS)) cols_eff = 11'(MAX_COLUMNS);
      rows_eff = rows_ff;
      if (rows_ff == 9'd0) rows_eff = 9'd1;
      if (rows_ff > 9'(atcp_pkg::RowLimit)) rows_eff = 9'(atcp_pkg::RowLimit);
   end

   atcp_pkg::state_type state_ff, state_in;
   atcp_pkg::mode_type  mode_ff, mode_in;
   logic [13:0] val_ff [MAX_PARAMS];
   logic [13:0] val_in [MAX_PARAMS];
   logic [MAX_PARAMS-1:0] pres_ff, pres_in;
   logic [PW-1:0] cnt_ff, cnt_in;
   logic [PW-1:0] idx_ff, idx_in;
   logic [8:0] col_ff, col_in;
   logic [7:0] row_ff, row_in;
   logic [23:0] fore_ff, fore_in, back_ff, back_in;

   // Queued result payloads (two slots).
   logic [1:0] op0_ff, op0_in, op1_ff, op1_in;
   logic [8:0] c0_ff, c0_in;
   logic [7:0] r0_ff, r0_in, g0_ff, g0_in;
   logic [9:0] e0_ff, e0_in;
   logic two_ff, two_in;

   // Clamped cursor as seen at the start of a byte.
   logic [9:0] ccol;
   logic [8:0] crow;
   always_comb begin
      ccol = {1'b0, col_ff};
      if ({1'b0, ccol} >= cols_eff) ccol = 10'(cols_eff - 11'd1);
      crow = {1'b0, row_ff};
      if (crow >= rows_eff) crow = rows_eff - 9'd1;
   end

   // SGR shared unit
   logic [13:0] sgr_val;
   logic [23:0] sgr_fore, sgr_back;
   logic [IW-1:0] sidx;
   assign sidx = idx_ff[IW-1:0];
   assign sgr_val = pres_ff[sidx] ? val_ff[sidx] : 14'd0;
   atcp_sgr_unit u_sgr (
      .value(sgr_val), .fore_cur(fore_ff), .back_cur(back_ff),
      .fore_next(sgr_fore), .back_next(sgr_back)
   );

   // A pending byte takes priority over a configuration write in idle.
   assign req_ready = (state_ff == atcp_pkg::ST_IDLE);
   assign csr_ready = (state_ff == atcp_pkg::ST_IDLE) && !req_valid;
   wire take = req_valid && req_ready;

   // Configuration write; the cursor is clamped into the new geometry.
   logic [9:0] columns_in;
   logic [8:0] rows_in;
   logic [10:0] cols_new;
   logic [8:0] rows_new;
   logic csr_take;
   assign csr_take = csr_valid && csr_ready;
   always_comb begin
      columns_in = columns_ff;
      rows_in = rows_ff;
      if (csr_take) begin
         if (csr_index == atcp_pkg::CSR_COLUMNS) columns_in = csr_data;
         else rows_in = csr_data[8:0];
      end
      cols_new = {1'b0, columns_in};
      if (columns_in == 10'd0) cols_new = 11'd1;
      if ({1'b0, columns_in} > 11'(MAX_COLUMNS)) cols_new = 11'(MAX_COLUMNS);
      rows_new = rows_in;
      if (rows_in == 9'd0) rows_new = 9'd1;
      if (rows_in > 9'(atcp_pkg::RowLimit)) rows_new = 9'(atcp_pkg::RowLimit);
   end

   // Datapath and next-state logic for byte processing.
   logic [IW-1:0] ci;
   logic [17:0] digit_v;
   logic [PW-1:0] fc;
   logic [13:0] p1, p2, kp;
   logic [14:0] sum;
   logic [7:0] ch;
   always_comb begin
      mode_in = mode_ff;
      for (int i = 0; i < MAX_PARAMS; i++) val_in[i] = val_ff[i];
      pres_in = pres_ff;
      cnt_in = cnt_ff;
      idx_in = idx_ff;
      col_in = col_ff;
      row_in = row_ff;
      fore_in = fore_ff;
      back_in = back_ff;
      op0_in = op0_ff; op1_in = op1_ff;
      c0_in = c0_ff; r0_in = r0_ff; g0_in = g0_ff; e0_in = e0_ff;
      two_in = two_ff;
      state_in = state_ff;
      ch = req_char_in;
      ci = cnt_ff[IW-1:0];
      digit_v = 18'd0;
      fc = cnt_ff;
      p1 = 14'd1; p2 = 14'd1; kp = 14'd0; sum = 15'd0;
      unique case (state_ff)
         atcp_pkg::ST_IDLE: begin
            if (csr_take) begin
               if ({2'b0, col_ff} >= cols_new) col_in = 9'(cols_new - 11'd1);
               if ({1'b0, row_ff} >= rows_new) row_in = 8'(rows_new - 9'd1);
            end
            if (take) begin
               col_in = ccol[8:0];
               row_in = crow[7:0];
               two_in = 1'b0;
               unique case (mode_ff)
                  atcp_pkg::PM_ESC: begin
                     if (ch == "[") begin
                        mode_in = atcp_pkg::PM_CSI;
                        cnt_in = '0;
                        pres_in = '0;
                     end else mode_in = atcp_pkg::PM_NORMAL;
                  end
                  atcp_pkg::PM_DEC: begin
                     if ((ch >= "A" && ch <= "Z") || (ch >= "a" && ch <= "z"))
                        mode_in = atcp_pkg::PM_NORMAL;
                  end
                  atcp_pkg::PM_CSI: begin
                     if (ch == "?") mode_in = atcp_pkg::PM_DEC;
                     else if (ch >= "0" && ch <= "9") begin
                        if (cnt_ff < PMAX) begin
                           digit_v = (pres_ff[ci] ? 18'(val_ff[ci]) : 18'd0) * 18'd10
                                     + 18'(ch - "0");
                           if (digit_v > 18'(atcp_pkg::ValueCap))
                              digit_v = 18'(atcp_pkg::ValueCap);
                           val_in[ci] = digit_v[13:0];
                           pres_in[ci] = 1'b1;
                        end
                     end else if (ch == ";") begin
                        if (cnt_ff < PMAX) begin
                           cnt_in = cnt_ff + 1'b1;
                           if (cnt_ff + 1'b1 < PMAX)
                              pres_in[IW'(cnt_ff + 1'b1)] = 1'b0;
                        end
                     end else begin
                        mode_in = atcp_pkg::PM_NORMAL;
                        if (cnt_ff < PMAX && pres_ff[ci]) fc = cnt_ff + 1'b1;
                        cnt_in = fc;
                        if (fc > 0 && pres_ff[0]) p1 = val_ff[0];
                        if (fc > 1 && pres_ff[1]) p2 = val_ff[1];
                        if (fc > 0 && pres_ff[0]) kp = val_ff[0];
                        case (ch)
                           "H", "f": begin
                              sum = (p1 > 0) ? 15'(p1 - 14'd1) : 15'd0;
                              row_in = (sum >= 15'(rows_eff)) ? 8'(rows_eff - 9'd1)
                                                              : sum[7:0];
                              sum = (p2 > 0) ? 15'(p2 - 14'd1) : 15'd0;
                              col_in = (sum >= 15'(cols_eff)) ? 9'(cols_eff - 11'd1)
                                                              : sum[8:0];
                           end
                           "A": row_in = (15'(crow) >= 15'(p1)) ? 8'(15'(crow) - 15'(p1))
                                                                 : 8'd0;
                           "B": begin
                              sum = 15'(crow) + 15'(p1);
                              row_in = (sum >= 15'(rows_eff)) ? 8'(rows_eff - 9'd1)
                                                              : sum[7:0];
                           end
                           "C": begin
                              sum = 15'(ccol) + 15'(p1);
                              col_in = (sum >= 15'(cols_eff)) ? 9'(cols_eff - 11'd1)
                                                              : sum[8:0];
                           end
                           "D": col_in = (15'(ccol) >= 15'(p1)) ? 9'(15'(ccol) - 15'(p1))
                                                                 : 9'd0;
                           "J": if (p1 == 14'd2) begin
                              col_in = 9'd0; row_in = 8'd0; cnt_in = '0;
                              op0_in = atcp_pkg::OP_CLEAR;
                              c0_in = 9'd0; r0_in = 8'd0; e0_in = 10'd0; g0_in = 8'h20;
                              state_in = atcp_pkg::ST_OUT1;
                           end
                           "K": begin
                              op0_in = atcp_pkg::OP_ERASE; r0_in = crow[7:0];
                              g0_in = 8'h20;
                              if (kp == 14'd0) begin
                                 c0_in = ccol[8:0]; e0_in = cols_eff[9:0];
                                 state_in = atcp_pkg::ST_OUT1;
                              end else if (kp == 14'd1) begin
                                 c0_in = 9'd0; e0_in = ccol + 10'd1;
                                 state_in = atcp_pkg::ST_OUT1;
                              end else if (kp == 14'd2) begin
                                 c0_in = 9'd0; e0_in = cols_eff[9:0];
                                 state_in = atcp_pkg::ST_OUT1;
                              end
                           end
                           "m": begin
                              if (fc == 0) begin
                                 fore_in = atcp_pkg::ForeSgr0; back_in = 24'd0;
                              end else begin
                                 idx_in = '0;
                                 state_in = atcp_pkg::ST_SGR;
                              end
                           end
                           default: ;
                        endcase
                     end
                  end
                  default: begin
                     if (ch == atcp_pkg::CharEsc) mode_in = atcp_pkg::PM_ESC;
                     else if (ch == 8'h0D) col_in = 9'd0;
                     else if (ch == 8'h0A) begin
                        col_in = 9'd0;
                        if (crow + 9'd1 >= rows_eff) begin
                           row_in = 8'(rows_eff - 9'd1);
                           op0_in = atcp_pkg::OP_SCROLL;
                           c0_in = 9'd0; r0_in = 8'd0; e0_in = 10'd0; g0_in = 8'h20;
                           state_in = atcp_pkg::ST_OUT1;
                        end else row_in = 8'(crow + 9'd1);
                     end else if (ch == 8'h08) begin
                        c0_in = (ccol != 10'd0) ? 9'(ccol - 10'd1) : 9'd0;
                        col_in = c0_in;
                        op0_in = atcp_pkg::OP_WRITE; r0_in = crow[7:0];
                        e0_in = 10'd0; g0_in = 8'h20;
                        state_in = atcp_pkg::ST_OUT1;
                     end else begin
                        op0_in = atcp_pkg::OP_WRITE;
                        c0_in = ccol[8:0]; r0_in = crow[7:0]; e0_in = 10'd0; g0_in = ch;
                        state_in = atcp_pkg::ST_OUT1;
                        if ({1'b0, ccol + 10'd1} >= cols_eff) begin
                           col_in = 9'd0;
                           if (crow + 9'd1 < rows_eff) row_in = 8'(crow + 9'd1);
                           else begin
                              two_in = 1'b1; op1_in = atcp_pkg::OP_SCROLL;
                           end
                        end else col_in = 9'(ccol + 10'd1);
                     end
                  end
               endcase
            end
         end
         atcp_pkg::ST_SGR: begin
            fore_in = sgr_fore;
            back_in = sgr_back;
            idx_in = idx_ff + 1'b1;
            if (idx_ff + 1'b1 >= cnt_ff || idx_ff + 1'b1 >= PMAX)
               state_in = atcp_pkg::ST_IDLE;
         end
         atcp_pkg::ST_OUT1: begin
            if (rsp_ready) state_in = two_ff ? atcp_pkg::ST_OUT2 : atcp_pkg::ST_IDLE;
         end
         atcp_pkg::ST_OUT2: begin
            if (rsp_ready) state_in = atcp_pkg::ST_IDLE;
         end
         default: state_in = atcp_pkg::ST_IDLE;
      endcase
   end

   // Output decode
   always_comb begin
      rsp_valid = 1'b0;
      rsp_op = op0_ff; rsp_cell_col = c0_ff; rsp_cell_row = r0_ff;
      rsp_span_end = e0_ff; rsp_glyph_code = g0_ff; rsp_last_op = 1'b1;
      unique case (state_ff)
         atcp_pkg::ST_OUT1: begin
            rsp_valid = 1'b1; rsp_last_op = !two_ff;
         end
         atcp_pkg::ST_OUT2: begin
            rsp_valid = 1'b1; rsp_op = op1_ff; rsp_cell_col = 9'd0;
            rsp_cell_row = 8'd0; rsp_span_end = 10'd0; rsp_glyph_code = 8'h20;
         end
         default: ;
      endcase
      rsp_fore_rgb = fore_ff;
      rsp_back_rgb = back_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= atcp_pkg::ST_IDLE;
         mode_ff <= atcp_pkg::PM_NORMAL;
         pres_ff <= '0;
         cnt_ff <= '0;
         idx_ff <= '0;
         col_ff <= 9'd0;
         row_ff <= 8'd0;
         fore_ff <= atcp_pkg::ForeReset;
         back_ff <= 24'd0;
         columns_ff <= atcp_pkg::ColumnsReset;
         rows_ff <= atcp_pkg::RowsReset;
         two_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         mode_ff <= mode_in;
         pres_ff <= pres_in;
         cnt_ff <= cnt_in;
         idx_ff <= idx_in;
         col_ff <= col_in;
         row_ff <= row_in;
         fore_ff <= fore_in;
         back_ff <= back_in;
         columns_ff <= columns_in;
         rows_ff <= rows_in;
         two_ff <= two_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_PARAMS; i++) val_ff[i] <= val_in[i];
      op0_ff <= op0_in; op1_ff <= op1_in;
      c0_ff <= c0_in; r0_ff <= r0_in; g0_ff <= g0_in; e0_ff <= e0_in;
   end
endmodule

// File: src/atcp_checker.sv
// Port-level checker for the console parser core, bound to the parser core module.
// Depends on atcp_pkg.
module atcp_bind_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_last_op,
   input logic [1:0] rsp_op
);
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("ready while result pending");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_op))
      else $error("result dropped");
   a_second: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_op |=> rsp_valid && rsp_op == atcp_pkg::OP_SCROLL)
      else $error("missing wrap scroll");
endmodule

bind ansi_text_console_parser_core atcp_bind_checker u_chk (
   .clock(clock), .reset(reset), .req_ready(req_ready), .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready), .rsp_last_op(rsp_last_op), .rsp_op(rsp_op)
);
